// ===== src/mxps_pkg.sv =====
package mxps_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW  = 10;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned PixW    = 32;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  // Default frame limits handed to the top level.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MIRROR_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_XOR_COLOR    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd3;

  // Mirror mode codes; unlisted codes behave as no mirroring.
  localparam logic [ModeW-1:0] MODE_NONE       = 4'd0;
  localparam logic [ModeW-1:0] MODE_LEFT       = 4'd1;
  localparam logic [ModeW-1:0] MODE_RIGHT      = 4'd2;
  localparam logic [ModeW-1:0] MODE_DOWN       = 4'd3;
  localparam logic [ModeW-1:0] MODE_DOWN_LEFT  = 4'd4;
  localparam logic [ModeW-1:0] MODE_DOWN_RIGHT = 4'd5;
  localparam logic [ModeW-1:0] MODE_UP         = 4'd6;
  localparam logic [ModeW-1:0] MODE_UP_LEFT    = 4'd7;
  localparam logic [ModeW-1:0] MODE_UP_RIGHT   = 4'd8;

  // Write mask patterns.
  localparam logic [MaskW-1:0] MASK_NONE   = 4'b0000;
  localparam logic [MaskW-1:0] MASK_DIRECT = 4'b0001;
  localparam logic [MaskW-1:0] MASK_HORIZ  = 4'b0011;
  localparam logic [MaskW-1:0] MASK_VERT   = 4'b0101;
  localparam logic [MaskW-1:0] MASK_ALL    = 4'b1111;

  // Register values after reset.
  localparam logic [ModeW-1:0]  RESET_MODE   = MODE_LEFT;
  localparam logic [ColorW-1:0] RESET_COLOR  = 24'h000000;
  localparam logic [SizeW-1:0]  RESET_WIDTH  = 11'd320;
  localparam logic [SizeW-1:0]  RESET_HEIGHT = 11'd240;

  // Effective frame size after clamping to the supported maximum.
  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } frame_t;

endpackage

// ===== src/mxps_region.sv =====
module mxps_region #(
  parameter int MAX_WIDTH  = mxps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mxps_pkg::MAX_HEIGHT_DEF
) (
  input  logic [mxps_pkg::ModeW-1:0]  mirror_mode_i,
  input  logic [mxps_pkg::SizeW-1:0]  frame_width_i,
  input  logic [mxps_pkg::SizeW-1:0]  frame_height_i,
  input  logic [mxps_pkg::CoordW-1:0] pixel_x_i,
  input  logic [mxps_pkg::CoordW-1:0] pixel_y_i,
  output mxps_pkg::frame_t            frame_o,
  output logic [mxps_pkg::MaskW-1:0]  write_mask_o
);

  logic [mxps_pkg::SizeW-1:0] half_w;
  logic [mxps_pkg::SizeW-1:0] half_h;
  logic [mxps_pkg::SizeW-1:0] x_ext;
  logic [mxps_pkg::SizeW-1:0] y_ext;
  logic x_all, x_lo, x_hi;
  logic y_all, y_lo, y_hi;
  logic in_region;
  logic [mxps_pkg::MaskW-1:0] mode_mask;

  // Clamp the configured frame size to the supported maximum.
  always_comb begin
    if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      frame_o.width = mxps_pkg::SizeW'(MAX_WIDTH);
    end else begin
      frame_o.width = frame_width_i;
    end
    if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      frame_o.height = mxps_pkg::SizeW'(MAX_HEIGHT);
    end else begin
      frame_o.height = frame_height_i;
    end
  end

  // Floored half sizes and the halves that the pixel falls in.
  assign half_w = frame_o.width >> 1;
  assign half_h = frame_o.height >> 1;
  assign x_ext  = mxps_pkg::SizeW'(pixel_x_i);
  assign y_ext  = mxps_pkg::SizeW'(pixel_y_i);
  assign x_all  = x_ext < frame_o.width;
  assign x_lo   = x_ext < half_w;
  assign x_hi   = x_all && !x_lo;
  assign y_all  = y_ext < frame_o.height;
  assign y_lo   = y_ext < half_h;
  assign y_hi   = y_all && !y_lo;

  // The mode picks the source region and the set of mirrored copies.
  always_comb begin
    case (mirror_mode_i)
      mxps_pkg::MODE_LEFT: begin
        in_region = x_lo && y_all;
        mode_mask = mxps_pkg::MASK_HORIZ;
      end
      mxps_pkg::MODE_RIGHT: begin
        in_region = x_hi && y_all;
        mode_mask = mxps_pkg::MASK_HORIZ;
      end
      mxps_pkg::MODE_DOWN: begin
        in_region = x_all && y_hi;
        mode_mask = mxps_pkg::MASK_VERT;
      end
      mxps_pkg::MODE_DOWN_LEFT: begin
        in_region = x_lo && y_hi;
        mode_mask = mxps_pkg::MASK_ALL;
      end
      mxps_pkg::MODE_DOWN_RIGHT: begin
        in_region = x_hi && y_hi;
        mode_mask = mxps_pkg::MASK_ALL;
      end
      mxps_pkg::MODE_UP: begin
        in_region = x_all && y_lo;
        mode_mask = mxps_pkg::MASK_VERT;
      end
      mxps_pkg::MODE_UP_LEFT: begin
        in_region = x_lo && y_lo;
        mode_mask = mxps_pkg::MASK_ALL;
      end
      mxps_pkg::MODE_UP_RIGHT: begin
        in_region = x_hi && y_lo;
        mode_mask = mxps_pkg::MASK_ALL;
      end
      default: begin
        in_region = x_all && y_all;
        mode_mask = mxps_pkg::MASK_DIRECT;
      end
    endcase
  end

  assign write_mask_o = in_region ? mode_mask : mxps_pkg::MASK_NONE;

endmodule

// ===== src/mxps_addr.sv =====
module mxps_addr (
  input  mxps_pkg::frame_t            frame_i,
  input  logic [mxps_pkg::CoordW-1:0] pixel_x_i,
  input  logic [mxps_pkg::CoordW-1:0] pixel_y_i,
  input  logic [mxps_pkg::MaskW-1:0]  write_mask_i,
  output logic [mxps_pkg::AddrW-1:0]  direct_address_o,
  output logic [mxps_pkg::AddrW-1:0]  hflip_address_o,
  output logic [mxps_pkg::AddrW-1:0]  vflip_address_o,
  output logic [mxps_pkg::AddrW-1:0]  diag_address_o
);

  localparam int unsigned ProdW = 2 * mxps_pkg::SizeW;

  logic [mxps_pkg::SizeW-1:0] mirror_x;
  logic [mxps_pkg::SizeW-1:0] mirror_y;
  logic [ProdW-1:0] row_base;
  logic [ProdW-1:0] mirror_row_base;
  logic [ProdW-1:0] x_ext;
  logic [ProdW-1:0] mirror_x_ext;

  // Mirrored coordinates; only used when the pixel lies inside the frame.
  assign mirror_x = frame_i.width - mxps_pkg::SizeW'(pixel_x_i) - mxps_pkg::SizeW'(1);
  assign mirror_y = frame_i.height - mxps_pkg::SizeW'(pixel_y_i) - mxps_pkg::SizeW'(1);

  // Two row products are shared by the four addresses.
  assign row_base        = ProdW'(pixel_y_i) * ProdW'(frame_i.width);
  assign mirror_row_base = ProdW'(mirror_y) * ProdW'(frame_i.width);
  assign x_ext           = ProdW'(pixel_x_i);
  assign mirror_x_ext    = ProdW'(mirror_x);

  // A disabled copy reports address zero.
  always_comb begin
    direct_address_o = '0;
    hflip_address_o  = '0;
    vflip_address_o  = '0;
    diag_address_o   = '0;
    if (write_mask_i[0]) begin
      direct_address_o = mxps_pkg::AddrW'(row_base + x_ext);
    end
    if (write_mask_i[1]) begin
      hflip_address_o = mxps_pkg::AddrW'(row_base + mirror_x_ext);
    end
    if (write_mask_i[2]) begin
      vflip_address_o = mxps_pkg::AddrW'(mirror_row_base + x_ext);
    end
    if (write_mask_i[3]) begin
      diag_address_o = mxps_pkg::AddrW'(mirror_row_base + mirror_x_ext);
    end
  end

endmodule

// ===== src/mirror_xor_pixel_scatter_top.sv =====
// Mirroring pixel scatter.
// Input channel (in_valid_i / in_ready_o) carries one source pixel with its
// column and row. Output channel (out_valid_o / out_ready_i) carries one
// result item per input item: the pixel XOR the configured color, up to four
// linear frame addresses and a write mask telling which of them to write.
// Configuration uses a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
// registers are to be written by the user only while no item is in flight;
// the block itself does not enforce this. An accepted item sits in the input
// register, and its result is then registered in the result register and is
// on the output from then on. Throughput is one item per cycle while the
// receiver does not stall, with a single input register and single result
// register around the address logic (two row multipliers and four adders).
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; after that in_ready_o drops until
// the output moves. Reset empties both registers and loads the register
// defaults: mode left, color zero, frame 320 by 240.
module mirror_xor_pixel_scatter_top #(
  parameter int MAX_WIDTH  = mxps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mxps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mxps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mxps_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mxps_pkg::CoordW-1:0]   pixel_x_i,
  input  logic [mxps_pkg::CoordW-1:0]   pixel_y_i,
  input  logic [mxps_pkg::PixW-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mxps_pkg::AddrW-1:0]    direct_address_o,
  output logic [mxps_pkg::AddrW-1:0]    hflip_address_o,
  output logic [mxps_pkg::AddrW-1:0]    vflip_address_o,
  output logic [mxps_pkg::AddrW-1:0]    diag_address_o,
  output logic [mxps_pkg::MaskW-1:0]    write_mask_o,
  output logic [mxps_pkg::PixW-1:0]     pixel_out_o
);

  logic [mxps_pkg::ModeW-1:0]  mirror_mode_q;
  logic [mxps_pkg::ColorW-1:0] xor_color_q;
  logic [mxps_pkg::SizeW-1:0]  frame_width_q;
  logic [mxps_pkg::SizeW-1:0]  frame_height_q;

  logic                         in_valid_q;
  logic [mxps_pkg::CoordW-1:0]  pixel_x_q;
  logic [mxps_pkg::CoordW-1:0]  pixel_y_q;
  logic [mxps_pkg::PixW-1:0]    pixel_in_q;

  logic                         out_valid_q;
  logic [mxps_pkg::AddrW-1:0]   direct_address_q, direct_address_d;
  logic [mxps_pkg::AddrW-1:0]   hflip_address_q, hflip_address_d;
  logic [mxps_pkg::AddrW-1:0]   vflip_address_q, vflip_address_d;
  logic [mxps_pkg::AddrW-1:0]   diag_address_q, diag_address_d;
  logic [mxps_pkg::MaskW-1:0]   write_mask_q, write_mask_d;
  logic [mxps_pkg::PixW-1:0]    pixel_out_q, pixel_out_d;

  mxps_pkg::frame_t frame;
  logic in_fire;
  logic out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_mode_q  <= mxps_pkg::RESET_MODE;
      xor_color_q    <= mxps_pkg::RESET_COLOR;
      frame_width_q  <= mxps_pkg::RESET_WIDTH;
      frame_height_q <= mxps_pkg::RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mxps_pkg::CFG_MIRROR_MODE: begin
          mirror_mode_q <= cfg_wdata_i[mxps_pkg::ModeW-1:0];
        end
        mxps_pkg::CFG_XOR_COLOR: begin
          xor_color_q <= cfg_wdata_i[mxps_pkg::ColorW-1:0];
        end
        mxps_pkg::CFG_FRAME_WIDTH: begin
          frame_width_q <= cfg_wdata_i[mxps_pkg::SizeW-1:0];
        end
        mxps_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_q <= cfg_wdata_i[mxps_pkg::SizeW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the result register loads when empty or being drained, and
  // the input register takes an item when empty or passing its item on.
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pixel_x_q  <= pixel_x_i;
      pixel_y_q  <= pixel_y_i;
      pixel_in_q <= pixel_in_i;
    end
  end

  // Region check and write mask.
  mxps_region #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_region (
    .mirror_mode_i (mirror_mode_q),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .pixel_x_i     (pixel_x_q),
    .pixel_y_i     (pixel_y_q),
    .frame_o       (frame),
    .write_mask_o  (write_mask_d)
  );

  // Direct and mirrored addresses.
  mxps_addr u_addr (
    .frame_i         (frame),
    .pixel_x_i       (pixel_x_q),
    .pixel_y_i       (pixel_y_q),
    .write_mask_i    (write_mask_d),
    .direct_address_o(direct_address_d),
    .hflip_address_o (hflip_address_d),
    .vflip_address_o (vflip_address_d),
    .diag_address_o  (diag_address_d)
  );

  assign pixel_out_d = pixel_in_q ^ mxps_pkg::PixW'(xor_color_q);

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      direct_address_q <= direct_address_d;
      hflip_address_q  <= hflip_address_d;
      vflip_address_q  <= vflip_address_d;
      diag_address_q   <= diag_address_d;
      write_mask_q     <= write_mask_d;
      pixel_out_q      <= pixel_out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign direct_address_o = direct_address_q;
  assign hflip_address_o  = hflip_address_q;
  assign vflip_address_o  = vflip_address_q;
  assign diag_address_o   = diag_address_q;
  assign write_mask_o     = write_mask_q;
  assign pixel_out_o      = pixel_out_q;

  // The mask is always one of the patterns that a mode can produce.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (write_mask_q == mxps_pkg::MASK_NONE ||
                     write_mask_q == mxps_pkg::MASK_DIRECT ||
                     write_mask_q == mxps_pkg::MASK_HORIZ ||
                     write_mask_q == mxps_pkg::MASK_VERT ||
                     write_mask_q == mxps_pkg::MASK_ALL))
    else $error("write mask outside the legal patterns");

  // A copy that is not written reports address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((write_mask_q[0] || direct_address_q == '0) &&
                     (write_mask_q[1] || hflip_address_q == '0) &&
                     (write_mask_q[2] || vflip_address_q == '0) &&
                     (write_mask_q[3] || diag_address_q == '0)))
    else $error("disabled address is not zero");

  // An accepted item is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_valid_q)
    else $error("accepted item lost from the input register");

  // An item waiting in the input register moves on once the output drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_load) |=> out_valid_q)
    else $error("item not moved into the result register");

endmodule
